// ===== rtl/core/osss_pkg.sv =====
package osss_pkg;

    // Keys and results are 16 bits wide at the ports, whatever the universe size.
    localparam int KEY_W = 16;
    localparam int OP_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd1;
    localparam logic [OP_W-1:0] OP_SUCC   = 2'd2;
    localparam logic [OP_W-1:0] OP_PRED   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] value;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the request and start the first leaf read
        logic exec1;     // evaluate the first leaf word, perform an insert
        logic exec2;     // evaluate the second leaf word
        logic load_out;  // move the finished result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_second;  // a second leaf word must be read
    } dp_status_t;

endpackage

// ===== rtl/core/osss_ram.sv =====
module osss_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/core/osss_prio.sv =====
module osss_prio #(
    parameter int WIDTH    = 256,
    parameter bit FROM_TOP = 1'b0
) (
    input  logic [WIDTH-1:0]                         word,
    output logic                                     any,
    output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] idx
);

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] w_in;
    logic [WIDTH-1:0] iso;
    logic [IW-1:0]    pos;

    // Searching from the top is a search from the bottom of the reversed word.
    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            w_in[i] = FROM_TOP ? word[WIDTH-1-i] : word[i];
        end
        iso = w_in & (~w_in + WIDTH'(1));
        pos = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (iso[i]) begin
                pos = pos | IW'(i);
            end
        end
        idx = FROM_TOP ? (IW'(WIDTH - 1) - pos) : pos;
        any = |word;
    end

endmodule

// ===== rtl/core/osss_datapath.sv =====
module osss_datapath #(
    parameter int UNIVERSE_BITS = 16,
    parameter int CLUSTER_BITS  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  osss_pkg::req_t      s_data,
    input  osss_pkg::dp_cmd_t   cmd,
    output osss_pkg::dp_status_t status,
    output osss_pkg::rsp_t      m_data
);

    localparam int UB  = UNIVERSE_BITS;
    localparam int LB  = (CLUSTER_BITS < UNIVERSE_BITS) ? CLUSTER_BITS : UNIVERSE_BITS;
    localparam int HB  = UB - LB;
    localparam int NCL = 1 << HB;
    localparam int CW  = (HB > 0) ? HB : 1;
    localparam int LW  = 1 << LB;
    localparam int KW  = osss_pkg::KEY_W;

    logic [osss_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]             key_reg;
    logic [CW-1:0]             cs_reg;
    logic [NCL-1:0]            summary_reg;
    logic [KW-1:0]             min_reg;
    logic [KW-1:0]             max_reg;
    logic                      empty_reg;
    logic                      res_found_reg;
    logic [KW-1:0]             res_value_reg;
    osss_pkg::rsp_t            out_reg;

    logic [UB-1:0]  key_u;
    logic [UB-1:0]  s_key_u;
    logic [CW-1:0]  c_key;
    logic [CW-1:0]  s_cluster;
    logic [LB-1:0]  off;
    logic           in_range;

    logic [LW-1:0]  rdata;
    logic [LW-1:0]  row_w;
    logic [LW-1:0]  up_in;
    logic [LW-1:0]  dn_in;
    logic [NCL-1:0] su_in;
    logic [NCL-1:0] sd_in;
    logic           ru_any, rd_any, su_any, sd_any;
    logic [LB-1:0]  ru_idx, rd_idx;
    logic [CW-1:0]  su_idx, sd_idx;

    logic           hit;
    logic           found_c;
    logic [KW-1:0]  value_c;
    logic           need2;
    logic           do_write;
    logic [CW-1:0]  cs_c;
    logic           p2_found;
    logic [KW-1:0]  p2_value;

    logic           ram_we;
    logic           ram_re;
    logic [CW-1:0]  ram_addr;
    logic [LW-1:0]  ram_wdata;

    function automatic logic [KW-1:0] compose(input logic [CW-1:0] cl, input logic [LB-1:0] of);
        logic [UB-1:0] kv;
        kv = UB'({cl, of});
        return KW'(kv);
    endfunction

    assign key_u    = UB'(key_reg);
    assign s_key_u  = UB'(s_data.key);
    assign c_key    = CW'(key_u >> LB);
    assign s_cluster = CW'(s_key_u >> LB);
    assign off      = key_u[LB-1:0];
    assign in_range = ((32'(key_reg)) >> UB) == 32'd0;

    // A leaf word of an empty cluster was possibly never written; it reads as zero.
    assign row_w = cmd.exec2 ? rdata : (summary_reg[c_key] ? rdata : '0);
    assign hit   = row_w[off];

    always_comb begin
        for (int i = 0; i < LW; i++) begin
            up_in[i] = row_w[i] & (cmd.exec2 | (LB'(i) > off));
            dn_in[i] = row_w[i] & (cmd.exec2 | (LB'(i) < off));
        end
        for (int i = 0; i < NCL; i++) begin
            su_in[i] = summary_reg[i] & (CW'(i) > c_key);
            sd_in[i] = summary_reg[i] & (CW'(i) < c_key);
        end
    end

    osss_prio #(.WIDTH(LW), .FROM_TOP(1'b0)) u_row_up (
        .word(up_in), .any(ru_any), .idx(ru_idx)
    );
    osss_prio #(.WIDTH(LW), .FROM_TOP(1'b1)) u_row_dn (
        .word(dn_in), .any(rd_any), .idx(rd_idx)
    );
    osss_prio #(.WIDTH(NCL), .FROM_TOP(1'b0)) u_sum_up (
        .word(su_in), .any(su_any), .idx(su_idx)
    );
    osss_prio #(.WIDTH(NCL), .FROM_TOP(1'b1)) u_sum_dn (
        .word(sd_in), .any(sd_any), .idx(sd_idx)
    );

    // Evaluation of the first leaf word.
    always_comb begin
        found_c  = 1'b0;
        value_c  = key_reg;
        need2    = 1'b0;
        do_write = 1'b0;
        cs_c     = su_idx;
        unique case (op_reg)
            osss_pkg::OP_INSERT: begin
                if (in_range) begin
                    if (hit) begin
                        found_c = 1'b1;
                    end else begin
                        do_write = 1'b1;
                    end
                end
            end
            osss_pkg::OP_MEMBER: begin
                found_c = in_range & ~empty_reg & hit;
            end
            osss_pkg::OP_SUCC: begin
                cs_c = su_idx;
                if (!(empty_reg || key_reg >= max_reg)) begin
                    found_c = 1'b1;
                    if (key_reg < min_reg) begin
                        value_c = min_reg;
                    end else if (ru_any) begin
                        value_c = compose(c_key, ru_idx);
                    end else if (!su_any) begin
                        value_c = max_reg;
                    end else begin
                        need2 = 1'b1;
                    end
                end
            end
            osss_pkg::OP_PRED: begin
                cs_c = sd_idx;
                if (!(empty_reg || key_reg <= min_reg)) begin
                    found_c = 1'b1;
                    if (key_reg > max_reg) begin
                        value_c = max_reg;
                    end else if (rd_any) begin
                        value_c = compose(c_key, rd_idx);
                    end else if (!sd_any) begin
                        value_c = min_reg;
                    end else begin
                        need2 = 1'b1;
                    end
                end
            end
        endcase
    end

    // Evaluation of the second leaf word, taken from the nearest non-empty cluster.
    always_comb begin
        p2_found = 1'b1;
        if (op_reg == osss_pkg::OP_SUCC) begin
            p2_value = compose(cs_reg, ru_idx);
        end else if (rd_any) begin
            p2_value = compose(cs_reg, rd_idx);
        end else begin
            p2_value = min_reg;
        end
    end

    assign status.need_second = need2;

    assign ram_we    = cmd.exec1 & do_write;
    assign ram_re    = cmd.capture | (cmd.exec1 & need2);
    assign ram_addr  = cmd.capture ? s_cluster : (do_write ? c_key : cs_c);
    assign ram_wdata = row_w | (LW'(1) << off);

    osss_ram #(.WIDTH(LW), .DEPTH(NCL)) u_leaf_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    // Set bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            summary_reg <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            empty_reg   <= 1'b1;
        end else if (cmd.exec1 && do_write) begin
            summary_reg[c_key] <= 1'b1;
            empty_reg          <= 1'b0;
            if (empty_reg || key_reg < min_reg) begin
                min_reg <= key_reg;
            end
            if (empty_reg || key_reg > max_reg) begin
                max_reg <= key_reg;
            end
        end
    end

    // Request, intermediate and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_data.op;
            key_reg <= s_data.key;
        end
        if (cmd.exec1) begin
            cs_reg        <= cs_c;
            res_found_reg <= found_c;
            res_value_reg <= value_c;
        end
        if (cmd.exec2) begin
            res_found_reg <= p2_found;
            res_value_reg <= p2_value;
        end
        if (cmd.load_out) begin
            out_reg.found <= res_found_reg;
            out_reg.value <= res_value_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/core/osss_ctrl.sv =====
module osss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  osss_pkg::dp_status_t status,
    output osss_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LEAF1 = 2'd1;
    localparam logic [1:0] ST_LEAF2 = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LEAF1;
                end
            end
            ST_LEAF1: begin
                cmd.exec1  = 1'b1;
                state_next = status.need_second ? ST_LEAF2 : ST_DONE;
            end
            ST_LEAF2: begin
                cmd.exec2  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // The next request may enter in the same cycle that the result leaves.
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_LEAF1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/ordered_set_successor_search_top.sv =====
// Ordered set of keys with insert, membership, successor and predecessor requests.
// A request enters on the s_ channel (s_valid, s_ready, s_data with op and key); a transfer
// happens at a rising edge of aclk where s_valid and s_ready are both high. Each request
// produces exactly one result on the m_ channel (m_valid, m_ready, m_data with found and
// value), in request order.
// The set is a two-level bitmap: one leaf word per cluster in a single-port RAM with a
// registered read, a summary flop per cluster, and min, max and empty registers.
// After the input transfer a request passes LEAF1, then LEAF2 when a successor or
// predecessor search has to read the leaf word of a second, more distant cluster, then
// DONE, from which its result moves to the output register. A new request is taken in
// the cycle its predecessor's result moves to the output register, so the block does not
// take a request while another is still in LEAF1 or LEAF2.
// When the receiver stalls, the result waits in the output register while the next
// request is already processed; that request's result then waits in the datapath and
// s_ready stays low until the output register is free.
// aresetn is synchronous and active low. Reset empties the set at once; no clearing pass
// is needed because a leaf word is only trusted when its cluster's summary flop is set.
module ordered_set_successor_search_top #(
    parameter int UNIVERSE_BITS = 16,
    parameter int CLUSTER_BITS  = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  osss_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output osss_pkg::rsp_t m_data
);

    // Commands and status that join the controller and the datapath.
    osss_pkg::dp_cmd_t    cmd;
    osss_pkg::dp_status_t status;

    // The controller sequences the leaf reads and owns both handshakes.
    osss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the set and evaluates each request.
    osss_datapath #(
        .UNIVERSE_BITS (UNIVERSE_BITS),
        .CLUSTER_BITS  (CLUSTER_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

    // An accepted request is always evaluated in the very next cycle.
    a_capture_then_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.exec1)
        else $error("request was captured but not evaluated");

    // A result never overwrites one that the receiver has not taken yet.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten while stalled");

    // The capture and the two evaluation steps never overlap.
    a_phase_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.exec1, cmd.exec2}))
        else $error("overlapping datapath commands");

    // Right after an input transfer the block is busy and does not take another.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");

endmodule
